>>> rtl/core/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg: shared types, constants and the alphabet map for the decoder
// Holds the character codes, the output queue sizing and the sextet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CharW     = 8;
  localparam int unsigned SextetW   = 6;
  localparam int unsigned GroupW    = 4 * SextetW;
  localparam int unsigned MaxBytes  = 3;
  localparam int unsigned NBytesW   = 2;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CharW-1:0] CharCr  = 8'h0D;
  localparam logic [CharW-1:0] CharLf  = 8'h0A;
  localparam logic [CharW-1:0] CharPad = 8'h3D;

  typedef struct packed {
    logic [CharW-1:0] data;
    logic             last;
  } q_entry_t;

  // Map one character to its six-bit value; anything outside the alphabet is zero.
  function automatic logic [SextetW-1:0] sextet_of(input logic [CharW-1:0] c);
    logic [SextetW-1:0] s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s = 6'd62;
    end else if (c == 8'h2F) begin
      s = 6'd63;
    end
    return s;
  endfunction

endpackage

>>> rtl/core/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder: one-character-per-beat Base64 decoder
// Gathers characters into groups of four and emits the decoded bytes.
// ----------------------------------------------------------------------------
// Each input beat carries one ASCII character on tdata and an end-of-stream
// flag on tlast. CR and LF are skipped. Every other character takes the next
// place in a group of four; characters outside the alphabet count as zero.
// The fourth character completes the group, which emits one byte ('=' in the
// third place), two bytes ('=' in the fourth place) or three bytes, most
// significant first, with tlast high on the final byte of the group. A beat
// with tlast high drops any partial group and clears the group state; its
// character is ignored. Rate: one character is accepted every cycle while the
// queue has room for a full group. A beat is registered on acceptance and
// decoded when it advances, which writes its bytes into an eight-entry output
// queue; the first byte of a group is presented on the output from that queue
// once the bytes are written. The output port drains one byte per cycle while
// the receiver is ready, and the input stalls only while the queue has fewer
// than three free entries. No clearing pass after reset.
module base64_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // slave side
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_in
  input  logic       s_axis_tlast_i,   // end_of_data
  // master side
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] byte_out
  output logic       m_axis_tlast_o    // last_of_group
);

  // --------------------------------------------------------------------------
  // Input register: one beat, held until the queue has room for a full group
  // --------------------------------------------------------------------------
  logic                           in_valid_q;
  logic [b64d_pkg::CharW-1:0]     in_char_q;
  logic                           in_eod_q;
  logic                           advance;
  logic                           s_accept;

  // Queue state
  b64d_pkg::q_entry_t             queue_q [b64d_pkg::QueueDepth];
  logic [b64d_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [b64d_pkg::QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [b64d_pkg::QueueCntW-1:0] q_cnt_q, q_cnt_d;
  logic                           q_room;
  logic                           pop;

  // Group state
  logic [1:0]                     grp_pos_q, grp_pos_d;
  logic [b64d_pkg::SextetW-1:0]   sextet_q [3];
  logic [b64d_pkg::SextetW-1:0]   sextet_d [3];
  logic                           pad3_q, pad3_d;

  // Decode of the held beat
  logic                           is_break;
  logic                           take;
  logic [b64d_pkg::SextetW-1:0]   cur_sextet;
  logic [b64d_pkg::GroupW-1:0]    grp_value;
  logic [b64d_pkg::NBytesW-1:0]   push_n;
  b64d_pkg::q_entry_t             push_ent [b64d_pkg::MaxBytes];
  logic [b64d_pkg::QueuePtrW-1:0] push_idx [b64d_pkg::MaxBytes];

  // Advance the held beat only when three free entries are guaranteed.
  assign q_room          = (q_cnt_q <= b64d_pkg::QueueCntW'(b64d_pkg::QueueDepth
                                                          - b64d_pkg::MaxBytes));
  assign advance         = in_valid_q && q_room;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_char_q <= s_axis_tdata_i;
      in_eod_q  <= s_axis_tlast_i;
    end
  end

  // --------------------------------------------------------------------------
  // Group logic: collect sextets, complete the group on the fourth place
  // --------------------------------------------------------------------------
  assign is_break   = (in_char_q == b64d_pkg::CharCr) || (in_char_q == b64d_pkg::CharLf);
  assign take       = advance && !in_eod_q && !is_break;
  assign cur_sextet = b64d_pkg::sextet_of(in_char_q);

  always_comb begin
    grp_pos_d = grp_pos_q;
    sextet_d  = sextet_q;
    pad3_d    = pad3_q;
    push_n    = '0;
    grp_value = '0;

    if (advance && in_eod_q) begin
      // end of stream: drop the partial group
      grp_pos_d = '0;
      sextet_d  = '{default: '0};
      pad3_d    = 1'b0;
    end else if (take) begin
      if (grp_pos_q != 2'd3) begin
        for (int i = 0; i < 3; i++) begin
          if (grp_pos_q == 2'(i)) begin
            sextet_d[i] = cur_sextet;
          end
        end
        if (grp_pos_q == 2'd2) begin
          pad3_d = (in_char_q == b64d_pkg::CharPad);
        end
        grp_pos_d = grp_pos_q + 2'd1;
      end else begin
        // fourth place: padding zeroes every sextet from its place on
        if (pad3_q) begin
          push_n    = 2'd1;
          grp_value = {sextet_q[0], sextet_q[1], 12'd0};
        end else if (in_char_q == b64d_pkg::CharPad) begin
          push_n    = 2'd2;
          grp_value = {sextet_q[0], sextet_q[1], sextet_q[2], 6'd0};
        end else begin
          push_n    = 2'd3;
          grp_value = {sextet_q[0], sextet_q[1], sextet_q[2], cur_sextet};
        end
        grp_pos_d = '0;
        sextet_d  = '{default: '0};
        pad3_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_pos_q <= '0;
      sextet_q  <= '{default: '0};
      pad3_q    <= 1'b0;
    end else begin
      grp_pos_q <= grp_pos_d;
      sextet_q  <= sextet_d;
      pad3_q    <= pad3_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output queue: up to three writes and one read per cycle
  // --------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < b64d_pkg::MaxBytes; k++) begin
      push_ent[k].data = grp_value[b64d_pkg::GroupW-1-8*k -: b64d_pkg::CharW];
      push_ent[k].last = (push_n == b64d_pkg::NBytesW'(k + 1));
      push_idx[k]      = wr_ptr_q + b64d_pkg::QueuePtrW'(k);
    end
  end

  assign pop      = m_axis_tvalid_o && m_axis_tready_i;
  assign wr_ptr_d = wr_ptr_q + b64d_pkg::QueuePtrW'(push_n);
  assign rd_ptr_d = rd_ptr_q + b64d_pkg::QueuePtrW'(pop);
  assign q_cnt_d  = q_cnt_q + b64d_pkg::QueueCntW'(push_n) - b64d_pkg::QueueCntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < b64d_pkg::MaxBytes; k++) begin
      if (push_n > b64d_pkg::NBytesW'(k)) begin
        queue_q[push_idx[k]] <= push_ent[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      q_cnt_q  <= q_cnt_d;
    end
  end

  assign m_axis_tvalid_o = (q_cnt_q != '0);
  assign m_axis_tdata_o  = queue_q[rd_ptr_q].data;
  assign m_axis_tlast_o  = queue_q[rd_ptr_q].last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= b64d_pkg::QueueCntW'(b64d_pkg::QueueDepth))
    else $error("output queue overflow");

  a_push_on_fourth : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != '0) |-> (in_valid_q && grp_pos_q == 2'd3 && !in_eod_q))
    else $error("group emitted outside the fourth place");

  a_eod_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_eod_q) |=> (grp_pos_q == 2'd0 && !pad3_q))
    else $error("end of stream did not clear the group");

  a_push_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != '0) |-> (q_cnt_q + b64d_pkg::QueueCntW'(push_n)
                        <= b64d_pkg::QueueCntW'(b64d_pkg::QueueDepth)))
    else $error("group pushed without room");

endmodule
